// ===== rtl/core/lexer_rule_line_parser_core_assert.svh =====
// ----------------------------------------------------------------------------
// Lexer rule line parser assertion macros
// Shared concurrent assertion forms for the parser checker.
// ----------------------------------------------------------------------------
`ifndef LEXER_RULE_LINE_PARSER_CORE_ASSERT_SVH
`define LEXER_RULE_LINE_PARSER_CORE_ASSERT_SVH

// check prop at every rising clock edge outside reset
`define LRLP_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check prop at every rising clock edge, reset included
`define LRLP_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/lrlp_pkg.sv =====
// ----------------------------------------------------------------------------
// Lexer rule line parser package
// Shared constants, result codes and item types of the parser core.
// ----------------------------------------------------------------------------
`default_nettype none

package lrlp_pkg;

   localparam int POSITION_BITS_DEF    = 32;
   localparam int RULE_NUMBER_BITS_DEF = 16;
   localparam int QUEUE_DEPTH          = 2;

   localparam int KIND_BITS  = 3;
   localparam int ERROR_BITS = 3;

   localparam logic [KIND_BITS-1:0] KIND_SKIP     = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_NAME     = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_PATTERN  = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_RULE_END = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_ERROR    = 3'd4;
   localparam logic [KIND_BITS-1:0] KIND_FINISH   = 3'd5;

   localparam logic [ERROR_BITS-1:0] ERR_NONE          = 3'd0;
   localparam logic [ERROR_BITS-1:0] ERR_UNEXPECTED    = 3'd1;
   localparam logic [ERROR_BITS-1:0] ERR_EXPECTED_NAME = 3'd2;
   localparam logic [ERROR_BITS-1:0] ERR_BAD_OPTION    = 3'd3;
   localparam logic [ERROR_BITS-1:0] ERR_UNEXPECTED_END = 3'd4;

   localparam int OPT_WORD_LEN   = 6;
   localparam int OPT_HIT_BITS   = 8;
   localparam int OPT_INDEX_BITS = 3;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic                    alpha;
      logic                    digit;
      logic                    space;
      logic                    tab;
      logic                    cr;
      logic                    lf;
      logic                    hash;
      logic                    quote;
      logic                    lparen;
      logic                    rparen;
      logic                    colon;
      logic                    equal;
      logic [OPT_HIT_BITS-1:0] opt_hit;
   } class_type;

   typedef struct packed {
      class_type cls;
      byte_type  data;
      logic      eoi;
   } item_type;

endpackage

`default_nettype wire

// ===== rtl/core/lexer_rule_line_parser_core.sv =====
// The parser takes one text byte, or an end marker, per request transfer and
// answers each with exactly one response transfer, sustaining one transfer per
// clock while the response side takes responses. A request is written into the
// two-entry queue behind the byte classifier and then loaded into the response
// register, from which its response transfers. The grammar engine's state
// update sets the rate. A stalled response holds the engine, and the queue
// takes at most two more requests before the request side stalls. Error and
// clean-finish states are sticky until reset.
// ----------------------------------------------------------------------------
// Lexer rule line parser core
// Byte classifier, item queue and grammar engine for lexer rule lines.
// ----------------------------------------------------------------------------
`default_nettype none

module lexer_rule_line_parser_core
   import lrlp_pkg::*;
#(
   parameter int POSITION_BITS    = POSITION_BITS_DEF,
   parameter int RULE_NUMBER_BITS = RULE_NUMBER_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [7:0]                  req_byte_in,
   input  wire logic                        req_end_of_input,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [KIND_BITS-1:0]             rsp_kind,
   output logic [7:0]                       rsp_byte_out,
   output logic [RULE_NUMBER_BITS-1:0]      rsp_rule_number,
   output logic                             rsp_ignore_rule,
   output logic [ERROR_BITS-1:0]            rsp_error_code,
   output logic [POSITION_BITS-1:0]         rsp_error_position
);

   logic     queue_full;
   logic     push;
   item_type push_item;
   logic     pop;
   logic     avail;
   item_type head_item;

   lrlp_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte_in      (req_byte_in),
      .req_end_of_input (req_end_of_input),
      .queue_full       (queue_full),
      .push             (push),
      .push_item        (push_item)
   );

   lrlp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (queue_full),
      .avail     (avail),
      .head_item (head_item)
   );

   lrlp_engine #(
      .POSITION_BITS    (POSITION_BITS),
      .RULE_NUMBER_BITS (RULE_NUMBER_BITS)
   ) u_engine (
      .clock              (clock),
      .reset              (reset),
      .avail              (avail),
      .head_item          (head_item),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_byte_out       (rsp_byte_out),
      .rsp_rule_number    (rsp_rule_number),
      .rsp_ignore_rule    (rsp_ignore_rule),
      .rsp_error_code     (rsp_error_code),
      .rsp_error_position (rsp_error_position)
   );

endmodule

`default_nettype wire

// ===== rtl/core/lrlp_front.sv =====
// ----------------------------------------------------------------------------
// Lexer rule line parser front end
// Accepts request transfers and classifies each byte for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lrlp_front
   import lrlp_pkg::*;
(
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire byte_type req_byte_in,
   input  wire logic     req_end_of_input,
   input  wire logic     queue_full,
   output logic          push,
   output item_type      push_item
);

   localparam byte_type OPT_WORD [OPT_WORD_LEN] =
      '{8'h69, 8'h67, 8'h6E, 8'h6F, 8'h72, 8'h65};

   localparam byte_type CH_SPACE  = 8'h20;
   localparam byte_type CH_TAB    = 8'h09;
   localparam byte_type CH_LF     = 8'h0A;
   localparam byte_type CH_CR     = 8'h0D;
   localparam byte_type CH_HASH   = 8'h23;
   localparam byte_type CH_QUOTE  = 8'h22;
   localparam byte_type CH_LPAREN = 8'h28;
   localparam byte_type CH_RPAREN = 8'h29;
   localparam byte_type CH_COLON  = 8'h3A;
   localparam byte_type CH_EQUAL  = 8'h3D;

   class_type cls;

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      cls        = '0;
      cls.alpha  = req_byte_in inside {[8'h41:8'h5A], [8'h61:8'h7A]};
      cls.digit  = req_byte_in inside {[8'h30:8'h39]};
      cls.space  = (req_byte_in == CH_SPACE);
      cls.tab    = (req_byte_in == CH_TAB);
      cls.cr     = (req_byte_in == CH_CR);
      cls.lf     = (req_byte_in == CH_LF);
      cls.hash   = (req_byte_in == CH_HASH);
      cls.quote  = (req_byte_in == CH_QUOTE);
      cls.lparen = (req_byte_in == CH_LPAREN);
      cls.rparen = (req_byte_in == CH_RPAREN);
      cls.colon  = (req_byte_in == CH_COLON);
      cls.equal  = (req_byte_in == CH_EQUAL);
      for (int i = 0; i < OPT_WORD_LEN; i++) begin
         cls.opt_hit[i] = (req_byte_in == OPT_WORD[i]);
      end
   end

   assign push_item = '{cls: cls, data: req_byte_in, eoi: req_end_of_input};

endmodule

`default_nettype wire

// ===== rtl/core/lrlp_queue.sv =====
// ----------------------------------------------------------------------------
// Lexer rule line parser item queue
// Short register queue between the front end and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lrlp_queue
   import lrlp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   input  wire logic     pop,
   output logic          full,
   output logic          avail,
   output item_type      head_item
);

   localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS = PTR_BITS + 1;

   item_type              entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   assign full      = (count_ff == COUNT_BITS'(QUEUE_DEPTH));
   assign avail     = (count_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/lrlp_engine.sv =====
// ----------------------------------------------------------------------------
// Lexer rule line parser engine
// Runs the line grammar on classified items and registers each result.
// ----------------------------------------------------------------------------
`default_nettype none

module lrlp_engine
   import lrlp_pkg::*;
#(
   parameter int POSITION_BITS    = POSITION_BITS_DEF,
   parameter int RULE_NUMBER_BITS = RULE_NUMBER_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        avail,
   input  wire item_type                    head_item,
   output logic                             pop,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [KIND_BITS-1:0]             rsp_kind,
   output byte_type                         rsp_byte_out,
   output logic [RULE_NUMBER_BITS-1:0]      rsp_rule_number,
   output logic                             rsp_ignore_rule,
   output logic [ERROR_BITS-1:0]            rsp_error_code,
   output logic [POSITION_BITS-1:0]         rsp_error_position
);

   localparam int PHASE_BITS = 5;

   localparam logic [PHASE_BITS-1:0] PH_LINE      = 5'd0;
   localparam logic [PHASE_BITS-1:0] PH_LCOMMENT  = 5'd1;
   localparam logic [PHASE_BITS-1:0] PH_NAME      = 5'd2;
   localparam logic [PHASE_BITS-1:0] PH_OPT0      = 5'd3;
   localparam logic [PHASE_BITS-1:0] PH_OPT       = 5'd4;
   localparam logic [PHASE_BITS-1:0] PH_AFTER_OPT = 5'd5;
   localparam logic [PHASE_BITS-1:0] PH_SP1       = 5'd6;
   localparam logic [PHASE_BITS-1:0] PH_C1        = 5'd7;
   localparam logic [PHASE_BITS-1:0] PH_C2        = 5'd8;
   localparam logic [PHASE_BITS-1:0] PH_SP2A      = 5'd9;
   localparam logic [PHASE_BITS-1:0] PH_SP2       = 5'd10;
   localparam logic [PHASE_BITS-1:0] PH_BARE      = 5'd11;
   localparam logic [PHASE_BITS-1:0] PH_QUOTED    = 5'd12;
   localparam logic [PHASE_BITS-1:0] PH_TAIL      = 5'd13;
   localparam logic [PHASE_BITS-1:0] PH_TCOMMENT  = 5'd14;
   localparam logic [PHASE_BITS-1:0] PH_ERROR     = 5'd15;
   localparam logic [PHASE_BITS-1:0] PH_DONE      = 5'd16;

   localparam logic [POSITION_BITS-1:0]    POS_MAX  = {POSITION_BITS{1'b1}};
   localparam logic [RULE_NUMBER_BITS-1:0] RULE_MAX = {RULE_NUMBER_BITS{1'b1}};
   localparam logic [RULE_NUMBER_BITS-1:0] RULE_ONE = RULE_NUMBER_BITS'(1);
   localparam logic [OPT_INDEX_BITS-1:0]   OPT_FULL = OPT_INDEX_BITS'(OPT_WORD_LEN);

   logic [PHASE_BITS-1:0]       phase_ff, phase_in;
   logic [OPT_INDEX_BITS-1:0]   opt_idx_ff, opt_idx_in;
   logic                        opt_ok_ff, opt_ok_in;
   logic [POSITION_BITS-1:0]    opt_start_ff, opt_start_in;
   logic                        ign_ff, ign_in;
   logic [RULE_NUMBER_BITS-1:0] rule_ff, rule_in;
   logic [POSITION_BITS-1:0]    pos_ff, pos_in;
   logic                        dirty_ff, dirty_in;
   logic [ERROR_BITS-1:0]       err_code_ff, err_code_in;
   logic [POSITION_BITS-1:0]    err_pos_ff, err_pos_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [KIND_BITS-1:0]        kind_ff, kind_in;
   byte_type                    byte_ff, byte_in;
   logic [RULE_NUMBER_BITS-1:0] rnum_ff, rnum_in;
   logic                        rign_ff, rign_in;
   logic [ERROR_BITS-1:0]       ecode_ff, ecode_in;
   logic [POSITION_BITS-1:0]    epos_ff, epos_in;

   class_type cls;
   logic      alnum;
   logic      blank;
   logic      opt_step_ok;

   assign pop   = avail && (!rsp_valid_ff || rsp_ready);
   assign cls   = head_item.cls;
   assign alnum = cls.alpha || cls.digit;
   assign blank = cls.space || cls.tab;
   assign opt_step_ok = opt_ok_ff && cls.opt_hit[opt_idx_ff];

   always_comb begin
      phase_in     = phase_ff;
      opt_idx_in   = opt_idx_ff;
      opt_ok_in    = opt_ok_ff;
      opt_start_in = opt_start_ff;
      ign_in       = ign_ff;
      rule_in      = rule_ff;
      pos_in       = pos_ff;
      dirty_in     = dirty_ff;
      err_code_in  = err_code_ff;
      err_pos_in   = err_pos_ff;
      kind_in      = KIND_SKIP;
      rnum_in      = '0;
      rign_in      = 1'b0;

      if (phase_ff == PH_ERROR) begin
         kind_in = KIND_ERROR;
      end else if (phase_ff == PH_DONE) begin
         kind_in = KIND_FINISH;
      end else if (head_item.eoi) begin
         if (phase_ff == PH_LINE && !dirty_ff) begin
            phase_in = PH_DONE;
            kind_in  = KIND_FINISH;
         end else begin
            phase_in    = PH_ERROR;
            err_code_in = ERR_UNEXPECTED_END;
            err_pos_in  = pos_ff;
            kind_in     = KIND_ERROR;
         end
      end else begin
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + POSITION_BITS'(1);
         end
         // default the error position to this byte; restored where the byte fits
         err_pos_in = pos_in;
         case (phase_ff)
            PH_LINE: begin
               if (cls.space || cls.tab || cls.cr) begin
                  dirty_in = 1'b1;
               end else if (cls.hash) begin
                  dirty_in = 1'b1;
                  phase_in = PH_LCOMMENT;
               end else if (cls.lf) begin
                  dirty_in = 1'b0;
               end else if (cls.alpha) begin
                  kind_in  = KIND_NAME;
                  phase_in = PH_NAME;
               end else begin
                  kind_in     = KIND_ERROR;
                  err_code_in = ERR_EXPECTED_NAME;
               end
            end
            PH_LCOMMENT: begin
               if (cls.lf) begin
                  phase_in = PH_LINE;
                  dirty_in = 1'b0;
               end
            end
            PH_NAME: begin
               if (alnum) begin
                  kind_in = KIND_NAME;
               end else if (cls.lparen) begin
                  phase_in = PH_OPT0;
               end else if (blank) begin
                  phase_in = PH_SP1;
               end else begin
                  kind_in     = KIND_ERROR;
                  err_code_in = ERR_UNEXPECTED;
               end
            end
            PH_OPT0: begin
               if (cls.alpha) begin
                  opt_start_in = pos_in;
                  opt_idx_in   = cls.opt_hit[0] ? OPT_INDEX_BITS'(1) : '0;
                  opt_ok_in    = cls.opt_hit[0];
                  phase_in     = PH_OPT;
               end else begin
                  kind_in     = KIND_ERROR;
                  err_code_in = ERR_EXPECTED_NAME;
               end
            end
            PH_OPT: begin
               if (alnum) begin
                  if (opt_step_ok) begin
                     opt_idx_in = opt_idx_ff + OPT_INDEX_BITS'(1);
                  end else begin
                     opt_ok_in = 1'b0;
                  end
               end else if (cls.rparen) begin
                  if (opt_ok_ff && opt_idx_ff == OPT_FULL) begin
                     ign_in   = 1'b1;
                     phase_in = PH_AFTER_OPT;
                  end else begin
                     kind_in     = KIND_ERROR;
                     err_code_in = ERR_BAD_OPTION;
                     err_pos_in  = opt_start_ff;
                  end
               end else begin
                  kind_in     = KIND_ERROR;
                  err_code_in = ERR_UNEXPECTED;
               end
            end
            PH_AFTER_OPT, PH_SP2A: begin
               if (blank) begin
                  phase_in = (phase_ff == PH_AFTER_OPT) ? PH_SP1 : PH_SP2;
               end else begin
                  kind_in     = KIND_ERROR;
                  err_code_in = ERR_UNEXPECTED;
               end
            end
            PH_SP1: begin
               if (cls.colon) begin
                  phase_in = PH_C1;
               end else if (!blank) begin
                  kind_in     = KIND_ERROR;
                  err_code_in = ERR_UNEXPECTED;
               end
            end
            PH_C1: begin
               if (cls.colon) begin
                  phase_in = PH_C2;
               end else begin
                  kind_in     = KIND_ERROR;
                  err_code_in = ERR_UNEXPECTED;
               end
            end
            PH_C2: begin
               if (cls.equal) begin
                  phase_in = PH_SP2A;
               end else begin
                  kind_in     = KIND_ERROR;
                  err_code_in = ERR_UNEXPECTED;
               end
            end
            PH_SP2, PH_BARE: begin
               if (phase_ff == PH_SP2 && blank) begin
                  phase_in = PH_SP2;
               end else if (phase_ff == PH_SP2 && cls.quote) begin
                  phase_in = PH_QUOTED;
               end else if (cls.tab || cls.cr || cls.space) begin
                  phase_in = PH_TAIL;
               end else if (cls.hash) begin
                  phase_in = PH_TCOMMENT;
               end else if (cls.lf) begin
                  kind_in = KIND_RULE_END;
               end else begin
                  kind_in  = KIND_PATTERN;
                  phase_in = PH_BARE;
               end
            end
            PH_QUOTED: begin
               if (cls.quote) begin
                  phase_in = PH_TAIL;
               end else if (cls.tab || cls.lf || cls.cr) begin
                  kind_in     = KIND_ERROR;
                  err_code_in = ERR_UNEXPECTED;
               end else begin
                  kind_in = KIND_PATTERN;
               end
            end
            PH_TAIL: begin
               if (cls.hash) begin
                  phase_in = PH_TCOMMENT;
               end else if (cls.lf) begin
                  kind_in = KIND_RULE_END;
               end else if (!(cls.space || cls.tab || cls.cr)) begin
                  kind_in     = KIND_ERROR;
                  err_code_in = ERR_UNEXPECTED;
               end
            end
            PH_TCOMMENT: begin
               if (cls.lf) begin
                  kind_in = KIND_RULE_END;
               end
            end
            default: begin
               kind_in     = KIND_ERROR;
               err_code_in = ERR_UNEXPECTED;
            end
         endcase

         if (kind_in == KIND_ERROR) begin
            phase_in = PH_ERROR;
         end else begin
            err_code_in = err_code_ff;
            err_pos_in  = err_pos_ff;
         end

         if (kind_in == KIND_RULE_END) begin
            rnum_in  = rule_ff;
            rign_in  = ign_ff;
            rule_in  = (rule_ff != RULE_MAX) ? rule_ff + RULE_ONE : rule_ff;
            ign_in   = 1'b0;
            phase_in = PH_LINE;
            dirty_in = 1'b0;
         end
      end

      byte_in  = (kind_in == KIND_NAME || kind_in == KIND_PATTERN) ? head_item.data : '0;
      ecode_in = (kind_in == KIND_ERROR) ? err_code_in : ERR_NONE;
      epos_in  = (kind_in == KIND_ERROR) ? err_pos_in : '0;

      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LINE;
         opt_idx_ff   <= '0;
         opt_ok_ff    <= 1'b1;
         opt_start_ff <= '0;
         ign_ff       <= 1'b0;
         rule_ff      <= RULE_ONE;
         pos_ff       <= '0;
         dirty_ff     <= 1'b0;
         err_code_ff  <= ERR_NONE;
         err_pos_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff     <= phase_in;
            opt_idx_ff   <= opt_idx_in;
            opt_ok_ff    <= opt_ok_in;
            opt_start_ff <= opt_start_in;
            ign_ff       <= ign_in;
            rule_ff      <= rule_in;
            pos_ff       <= pos_in;
            dirty_ff     <= dirty_in;
            err_code_ff  <= err_code_in;
            err_pos_ff   <= err_pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff  <= kind_in;
         byte_ff  <= byte_in;
         rnum_ff  <= rnum_in;
         rign_ff  <= rign_in;
         ecode_ff <= ecode_in;
         epos_ff  <= epos_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_byte_out       = byte_ff;
   assign rsp_rule_number    = rnum_ff;
   assign rsp_ignore_rule    = rign_ff;
   assign rsp_error_code     = ecode_ff;
   assign rsp_error_position = epos_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lrlp_checker.sv =====
// ----------------------------------------------------------------------------
// Lexer rule line parser checker
// Port-level assertions on the parser core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lexer_rule_line_parser_core_assert.svh"

module lrlp_checker
   import lrlp_pkg::*;
#(
   parameter int POSITION_BITS    = POSITION_BITS_DEF,
   parameter int RULE_NUMBER_BITS = RULE_NUMBER_BITS_DEF
) (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [KIND_BITS-1:0]        rsp_kind,
   input wire logic [7:0]                  rsp_byte_out,
   input wire logic [RULE_NUMBER_BITS-1:0] rsp_rule_number,
   input wire logic                        rsp_ignore_rule,
   input wire logic [ERROR_BITS-1:0]       rsp_error_code,
   input wire logic [POSITION_BITS-1:0]    rsp_error_position
);

   `LRLP_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
         $stable(rsp_byte_out) && $stable(rsp_error_position),
      "response dropped or changed while stalled")
   `LRLP_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !rsp_valid,
      "response valid right after reset")
   `LRLP_ASSERT(a_byte_only_data, clock, reset,
      rsp_valid && rsp_kind != KIND_NAME && rsp_kind != KIND_PATTERN |-> rsp_byte_out == 8'd0,
      "byte shown on a non-data response")
   `LRLP_ASSERT(a_error_fields, clock, reset,
      rsp_valid && rsp_kind != KIND_ERROR |->
         rsp_error_code == ERR_NONE && rsp_error_position == '0,
      "error fields set outside an error")
   `LRLP_ASSERT(a_rule_fields, clock, reset,
      rsp_valid && rsp_kind != KIND_RULE_END |-> rsp_rule_number == '0 && !rsp_ignore_rule,
      "rule fields set outside a rule end")

endmodule

bind lexer_rule_line_parser_core lrlp_checker #(
   .POSITION_BITS    (POSITION_BITS),
   .RULE_NUMBER_BITS (RULE_NUMBER_BITS)
) u_lrlp_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_kind           (rsp_kind),
   .rsp_byte_out       (rsp_byte_out),
   .rsp_rule_number    (rsp_rule_number),
   .rsp_ignore_rule    (rsp_ignore_rule),
   .rsp_error_code     (rsp_error_code),
   .rsp_error_position (rsp_error_position)
);

`default_nettype wire

// ===== tb/lexer_rule_line_parser_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lexer rule line parser core testbench
// Streams directed and random rule text through the parser, one byte per
// request transfer. A grammar tracker in the bench works out the expected
// response of every accepted byte, and a monitor compares each response
// transfer field by field. The run ends on one randomly chosen end-of-text or
// error case, followed by a few transfers that must repeat the sticky answer.
// ----------------------------------------------------------------------------

module lexer_rule_line_parser_core_tb;
   import lrlp_pkg::*;

   localparam byte_type CH_TAB    = 8'h09;
   localparam byte_type CH_LF     = 8'h0A;
   localparam byte_type CH_CR     = 8'h0D;
   localparam byte_type CH_SP     = 8'h20;
   localparam byte_type CH_QUOTE  = 8'h22;
   localparam byte_type CH_HASH   = 8'h23;
   localparam byte_type CH_LPAREN = 8'h28;
   localparam byte_type CH_RPAREN = 8'h29;
   localparam byte_type CH_COLON  = 8'h3A;

   localparam logic [8*OPT_WORD_LEN-1:0] OPT_WORD = "ignore";

   typedef enum logic [4:0] {
      AT_LINE_START, IN_LINE_COMMENT, IN_NAME, OPT_OPEN, IN_OPTION, AFTER_OPTION,
      BEFORE_ASSIGN, SEEN_COLON, SEEN_COLONS, AFTER_ASSIGN, BEFORE_PATTERN,
      IN_BARE, IN_QUOTED, IN_TAIL, IN_TAIL_COMMENT, HELD_ERROR, FINISHED
   } parse_phase_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]            kind;
      byte_type                        byte_out;
      logic [RULE_NUMBER_BITS_DEF-1:0] rule_number;
      logic                            ignore_rule;
      logic [ERROR_BITS-1:0]           error_code;
      logic [POSITION_BITS_DEF-1:0]    error_position;
   } parse_result_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   byte_type                        req_byte_in;
   logic                            req_end_of_input;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic [KIND_BITS-1:0]            rsp_kind;
   logic [7:0]                      rsp_byte_out;
   logic [RULE_NUMBER_BITS_DEF-1:0] rsp_rule_number;
   logic                            rsp_ignore_rule;
   logic [ERROR_BITS-1:0]           rsp_error_code;
   logic [POSITION_BITS_DEF-1:0]    rsp_error_position;

   // grammar tracker state
   parse_phase_type                 phase;
   logic [OPT_INDEX_BITS-1:0]       opt_index;
   logic                            opt_ok;
   logic [POSITION_BITS_DEF-1:0]    opt_start_pos;
   logic                            ignore_flag;
   logic [RULE_NUMBER_BITS_DEF-1:0] rule_count;
   logic [POSITION_BITS_DEF-1:0]    byte_count;
   logic                            line_dirty;
   logic [ERROR_BITS-1:0]           held_code;
   logic [POSITION_BITS_DEF-1:0]    held_pos;

   parse_result_type pending_results[$];

   int    send_idle_pct;
   int    rsp_stall_pct;
   int    sent_items;
   int    mismatch_count;
   int    rules_closed;
   int    name_bytes;
   int    pattern_bytes;
   string end_case;

   lexer_rule_line_parser_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_byte_in        (req_byte_in),
      .req_end_of_input   (req_end_of_input),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_byte_out       (rsp_byte_out),
      .rsp_rule_number    (rsp_rule_number),
      .rsp_ignore_rule    (rsp_ignore_rule),
      .rsp_error_code     (rsp_error_code),
      .rsp_error_position (rsp_error_position)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(2_000_000);
      $display("lexer_rule_line_parser_core_tb: done, errors");
      $finish;
   end

   function automatic logic is_letter(input byte_type c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic is_letter_or_digit(input byte_type c);
      return is_letter(c) || (c >= "0" && c <= "9");
   endfunction

   function automatic logic is_blank(input byte_type c);
      return c == CH_SP || c == CH_TAB;
   endfunction

   function automatic logic [KIND_BITS-1:0] raise_error(input logic [ERROR_BITS-1:0] code,
                                                        input logic [POSITION_BITS_DEF-1:0] pos);
      phase = HELD_ERROR;
      held_code = code;
      held_pos = pos;
      return KIND_ERROR;
   endfunction

   function automatic void match_option(input byte_type c);
      if (opt_ok && opt_index < OPT_WORD_LEN &&
          c == OPT_WORD[8*(OPT_WORD_LEN-1-opt_index) +: 8]) begin
         opt_index++;
      end else begin
         opt_ok = 1'b0;
      end
   endfunction

   function automatic parse_result_type close_rule();
      parse_result_type r;
      r = '0;
      r.kind = KIND_RULE_END;
      r.rule_number = rule_count;
      r.ignore_rule = ignore_flag;
      if (rule_count != '1) rule_count++;
      ignore_flag = 1'b0;
      phase = AT_LINE_START;
      line_dirty = 1'b0;
      rules_closed++;
      return r;
   endfunction

   // advance the tracker by one accepted transfer and return its response
   function automatic parse_result_type parse_byte(input byte_type c, input logic eoi);
      parse_result_type r;
      r = '0;
      if (phase == HELD_ERROR) begin
         r.kind = KIND_ERROR;
      end else if (phase == FINISHED) begin
         r.kind = KIND_FINISH;
      end else if (eoi) begin
         if (phase == AT_LINE_START && !line_dirty) begin
            phase = FINISHED;
            r.kind = KIND_FINISH;
         end else begin
            r.kind = raise_error(ERR_UNEXPECTED_END, byte_count);
         end
      end else begin
         if (byte_count != '1) byte_count++;
         case (phase)
            AT_LINE_START: begin
               if (c == CH_SP || c == CH_TAB || c == CH_CR) line_dirty = 1'b1;
               else if (c == CH_HASH) begin
                  line_dirty = 1'b1;
                  phase = IN_LINE_COMMENT;
               end else if (c == CH_LF) line_dirty = 1'b0;
               else if (is_letter(c)) begin
                  r.kind = KIND_NAME;
                  phase = IN_NAME;
               end else r.kind = raise_error(ERR_EXPECTED_NAME, byte_count);
            end
            IN_LINE_COMMENT: begin
               if (c == CH_LF) begin
                  phase = AT_LINE_START;
                  line_dirty = 1'b0;
               end
            end
            IN_NAME: begin
               if (is_letter_or_digit(c)) r.kind = KIND_NAME;
               else if (c == CH_LPAREN) phase = OPT_OPEN;
               else if (is_blank(c)) phase = BEFORE_ASSIGN;
               else r.kind = raise_error(ERR_UNEXPECTED, byte_count);
            end
            OPT_OPEN: begin
               if (is_letter(c)) begin
                  opt_start_pos = byte_count;
                  opt_index = '0;
                  opt_ok = 1'b1;
                  match_option(c);
                  phase = IN_OPTION;
               end else r.kind = raise_error(ERR_EXPECTED_NAME, byte_count);
            end
            IN_OPTION: begin
               if (is_letter_or_digit(c)) match_option(c);
               else if (c == CH_RPAREN) begin
                  if (opt_ok && opt_index == OPT_WORD_LEN) begin
                     ignore_flag = 1'b1;
                     phase = AFTER_OPTION;
                  end else r.kind = raise_error(ERR_BAD_OPTION, opt_start_pos);
               end else r.kind = raise_error(ERR_UNEXPECTED, byte_count);
            end
            AFTER_OPTION: begin
               if (is_blank(c)) phase = BEFORE_ASSIGN;
               else r.kind = raise_error(ERR_UNEXPECTED, byte_count);
            end
            BEFORE_ASSIGN: begin
               if (c == CH_COLON) phase = SEEN_COLON;
               else if (!is_blank(c)) r.kind = raise_error(ERR_UNEXPECTED, byte_count);
            end
            SEEN_COLON: begin
               if (c == CH_COLON) phase = SEEN_COLONS;
               else r.kind = raise_error(ERR_UNEXPECTED, byte_count);
            end
            SEEN_COLONS: begin
               if (c == "=") phase = AFTER_ASSIGN;
               else r.kind = raise_error(ERR_UNEXPECTED, byte_count);
            end
            AFTER_ASSIGN: begin
               if (is_blank(c)) phase = BEFORE_PATTERN;
               else r.kind = raise_error(ERR_UNEXPECTED, byte_count);
            end
            BEFORE_PATTERN, IN_BARE: begin
               if (phase == BEFORE_PATTERN && is_blank(c)) ;
               else if (phase == BEFORE_PATTERN && c == CH_QUOTE) phase = IN_QUOTED;
               else if (c == CH_TAB || c == CH_CR || c == CH_SP) phase = IN_TAIL;
               else if (c == CH_HASH) phase = IN_TAIL_COMMENT;
               else if (c == CH_LF) r = close_rule();
               else begin
                  r.kind = KIND_PATTERN;
                  phase = IN_BARE;
               end
            end
            IN_QUOTED: begin
               if (c == CH_QUOTE) phase = IN_TAIL;
               else if (c == CH_TAB || c == CH_LF || c == CH_CR)
                  r.kind = raise_error(ERR_UNEXPECTED, byte_count);
               else r.kind = KIND_PATTERN;
            end
            IN_TAIL: begin
               if (c == CH_HASH) phase = IN_TAIL_COMMENT;
               else if (c == CH_LF) r = close_rule();
               else if (!(c == CH_SP || c == CH_TAB || c == CH_CR))
                  r.kind = raise_error(ERR_UNEXPECTED, byte_count);
            end
            IN_TAIL_COMMENT: begin
               if (c == CH_LF) r = close_rule();
            end
            default: r.kind = raise_error(ERR_UNEXPECTED, byte_count);
         endcase
         if (r.kind == KIND_NAME || r.kind == KIND_PATTERN) r.byte_out = c;
         if (r.kind == KIND_NAME) name_bytes++;
         if (r.kind == KIND_PATTERN) pattern_bytes++;
      end
      if (r.kind == KIND_ERROR) begin
         r.error_code = held_code;
         r.error_position = held_pos;
      end
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (mismatch_count < 50)
         $display("%0t mismatch: %s got %0h want %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // compare each response transfer with the oldest pending result
   always @(posedge clock) begin : check_rsp
      parse_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_results.size() == 0) begin
            flag_mismatch("response with nothing pending, kind", 32'(rsp_kind), 32'd0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_kind !== want.kind)
               flag_mismatch("kind", 32'(rsp_kind), 32'(want.kind));
            if (rsp_byte_out !== want.byte_out)
               flag_mismatch("byte_out", 32'(rsp_byte_out), 32'(want.byte_out));
            if (rsp_rule_number !== want.rule_number)
               flag_mismatch("rule_number", 32'(rsp_rule_number), 32'(want.rule_number));
            if (rsp_ignore_rule !== want.ignore_rule)
               flag_mismatch("ignore_rule", 32'(rsp_ignore_rule), 32'(want.ignore_rule));
            if (rsp_error_code !== want.error_code)
               flag_mismatch("error_code", 32'(rsp_error_code), 32'(want.error_code));
            if (rsp_error_position !== want.error_position)
               flag_mismatch("error_position", rsp_error_position, want.error_position);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // present one transfer and hold it until accepted
   task automatic send_item(input byte_type b, input logic eoi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte_in <= b;
      req_end_of_input <= eoi;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      pending_results.push_back(parse_byte(b, eoi));
      sent_items++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   function automatic byte_type rand_alnum(input logic letter_only);
      int n;
      n = letter_only ? $urandom_range(51) : $urandom_range(61);
      if (n < 26) return byte_type'("A" + n);
      if (n < 52) return byte_type'("a" + n - 26);
      return byte_type'("0" + n - 52);
   endfunction

   task automatic send_name();
      int n;
      n = $urandom_range(6);
      send_item(rand_alnum(1'b1), 1'b0);
      repeat (n) send_item(rand_alnum(1'b0), 1'b0);
   endtask

   task automatic send_blanks(input int lo, input int hi, input logic with_cr);
      int n;
      n = $urandom_range(hi, lo);
      repeat (n) begin
         if (with_cr && $urandom_range(2) == 0) send_item(CH_CR, 1'b0);
         else send_item($urandom_range(1) ? CH_SP : CH_TAB, 1'b0);
      end
   endtask

   task automatic send_comment();
      byte_type c;
      int n;
      n = $urandom_range(6);
      send_item(CH_HASH, 1'b0);
      repeat (n) begin
         do c = byte_type'($urandom_range(255)); while (c == CH_LF);
         send_item(c, 1'b0);
      end
   endtask

   task automatic send_line_end();
      case ($urandom_range(2))
         0: ;
         1: send_blanks(1, 3, 1'b1);
         default: begin
            send_blanks(0, 2, 1'b1);
            send_comment();
         end
      endcase
      send_item(CH_LF, 1'b0);
   endtask

   task automatic send_rule_line();
      byte_type c;
      int n;
      send_name();
      if ($urandom_range(3) == 0) send_text("(ignore)");
      send_blanks(1, 3, 1'b0);
      send_text("::=");
      send_blanks(1, 3, 1'b0);
      case ($urandom_range(5))
         0, 1, 2: begin
            n = $urandom_range(8, 1);
            for (int i = 0; i < n; i++) begin
               do c = byte_type'($urandom_range(255));
               while (c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_HASH ||
                      c == CH_SP || (i == 0 && c == CH_QUOTE));
               send_item(c, 1'b0);
            end
         end
         3, 4: begin
            n = $urandom_range(8);
            send_item(CH_QUOTE, 1'b0);
            repeat (n) begin
               do c = byte_type'($urandom_range(255));
               while (c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_QUOTE);
               send_item(c, 1'b0);
            end
            send_item(CH_QUOTE, 1'b0);
         end
         default: ;
      endcase
      send_line_end();
   endtask

   task automatic send_blank_line();
      case ($urandom_range(3))
         0: ;
         1: send_blanks(1, 3, 1'b1);
         2: begin
            send_blanks(0, 2, 1'b1);
            send_comment();
         end
         default: send_comment();
      endcase
      send_item(CH_LF, 1'b0);
   endtask

   task automatic test_directed_lines();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_text("Z9(ignore)\t::=\t\"");
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_text("\"\n");
      send_text("q ::= +#");
      send_item(8'h80, 1'b0);
      send_item(CH_LF, 1'b0);
   endtask

   task automatic test_random_text(input int idle, input int stall, input int count,
                                   input logic drain_midway);
      int stop_at;
      send_idle_pct = idle;
      rsp_stall_pct = stall;
      stop_at = sent_items + count;
      while (sent_items < stop_at) begin
         if (drain_midway && sent_items >= stop_at - count / 2) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_results.size() != 0) @(posedge clock);
            drain_midway = 1'b0;
         end
         if ($urandom_range(9) < 7) send_rule_line();
         else send_blank_line();
      end
   endtask

   task automatic test_end_of_text();
      byte_type c;
      send_idle_pct = 20;
      rsp_stall_pct = 20;
      case ($urandom_range(11))
         0: begin
            end_case = "clean finish";
            send_item(byte_type'($urandom_range(255)), 1'b1);
         end
         1: begin
            end_case = "end after blanks";
            send_blanks(1, 3, 1'b1);
            send_item(byte_type'($urandom_range(255)), 1'b1);
         end
         2: begin
            end_case = "end inside open comment";
            send_comment();
            send_item(byte_type'($urandom_range(255)), 1'b1);
         end
         3: begin
            end_case = "end inside rule";
            send_name();
            send_text(" ::= x");
            send_item(byte_type'($urandom_range(255)), 1'b1);
         end
         4: begin
            end_case = "name start at line";
            do c = byte_type'($urandom_range(255));
            while (is_letter(c) || c == CH_SP || c == CH_TAB || c == CH_CR ||
                   c == CH_HASH || c == CH_LF);
            send_item(c, 1'b0);
         end
         5: begin
            end_case = "name start in option";
            send_name();
            send_item(CH_LPAREN, 1'b0);
            do c = byte_type'($urandom_range(255)); while (is_letter(c));
            send_item(c, 1'b0);
         end
         6: begin
            end_case = "bad option word";
            send_name();
            case ($urandom_range(3))
               0: send_text("(ign)");
               1: send_text("(ignorex)");
               2: send_text("(Ignore)");
               default: send_text("(x9)");
            endcase
         end
         7: begin
            end_case = "stray char in option";
            send_name();
            send_text("(ign");
            do c = byte_type'($urandom_range(255));
            while (is_letter_or_digit(c) || c == CH_RPAREN);
            send_item(c, 1'b0);
         end
         8: begin
            end_case = "control char in quoted pattern";
            send_name();
            send_text(" ::= \"ab");
            case ($urandom_range(2))
               0: send_item(CH_TAB, 1'b0);
               1: send_item(CH_CR, 1'b0);
               default: send_item(CH_LF, 1'b0);
            endcase
         end
         9: begin
            end_case = "stray char before assign";
            send_name();
            send_item(CH_SP, 1'b0);
            do c = byte_type'($urandom_range(255)); while (c == CH_COLON || is_blank(c));
            send_item(c, 1'b0);
         end
         10: begin
            end_case = "stray char in name";
            send_name();
            do c = byte_type'($urandom_range(255));
            while (is_letter_or_digit(c) || c == CH_LPAREN || is_blank(c));
            send_item(c, 1'b0);
         end
         default: begin
            end_case = "no blank after option";
            send_name();
            send_text("(ignore)");
            do c = byte_type'($urandom_range(255)); while (is_blank(c));
            send_item(c, 1'b0);
         end
      endcase
      // the answer must now hold whatever follows
      repeat (4) send_item(byte_type'($urandom_range(255)), 1'($urandom_range(1)));
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_byte_in <= '0;
      req_end_of_input <= 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      sent_items = 0;
      mismatch_count = 0;
      rules_closed = 0;
      name_bytes = 0;
      pattern_bytes = 0;
      end_case = "";
      phase = AT_LINE_START;
      opt_index = '0;
      opt_ok = 1'b1;
      opt_start_pos = '0;
      ignore_flag = 1'b0;
      rule_count = RULE_NUMBER_BITS_DEF'(1);
      byte_count = '0;
      line_dirty = 1'b0;
      held_code = ERR_NONE;
      held_pos = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed_lines();
      test_random_text(0, 0, 230, 1'b0);
      test_random_text(58, 0, 230, 1'b0);
      test_random_text(0, 58, 230, 1'b0);
      test_random_text(38, 38, 230, 1'b1);
      test_end_of_text();

      req_valid <= 1'b0;
      for (int n = 0; n < 10000 && pending_results.size() != 0; n++) @(posedge clock);
      repeat (8) @(posedge clock);
      while (pending_results.size() != 0) begin
         flag_mismatch("missing response, kind", 32'd0, 32'(pending_results[0].kind));
         void'(pending_results.pop_front());
      end

      $display("covered %0d transfers: %0d rules closed, %0d name and %0d pattern bytes",
               sent_items, rules_closed, name_bytes, pattern_bytes);
      $display("text ended with: %s", end_case);
      if (mismatch_count == 0) begin
         $display("lexer_rule_line_parser_core_tb: done, clean");
      end else begin
         $display("lexer_rule_line_parser_core_tb: done, errors");
      end
      $finish;
   end

endmodule
